>>> rtl/dbm_pkg.sv
// Shared types, constants and the log2 mantissa table function of the peak meter.
// Used by every module of the block; depends on nothing else.
package dbm_pkg;

  localparam int unsigned SampleBitsDef   = 24;
  localparam int unsigned LogTableBitsDef = 6;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_EOB    = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_ACK    = 2'd3
  } req_e;

  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_CLIP_THRESHOLD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_RUN_LENGTH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DB          = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DB          = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ATTACK_COEFF    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_COEFF     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PEAK_DECAY_STEP = 3'd7;

  typedef struct packed {
    logic [22:0]        clip_threshold;
    logic [7:0]         clip_run_length;
    logic signed [15:0] min_db;
    logic signed [15:0] max_db;
    logic [15:0]        attack_coeff;
    logic [15:0]        decay_coeff;
    logic [15:0]        hold_ticks;
    logic [14:0]        peak_decay_step;
  } cfg_t;

  localparam logic signed [15:0] FloorReset = -16'sd15360;

  localparam cfg_t CfgReset = '{
    clip_threshold:  23'd7476617,
    clip_run_length: 8'd3,
    min_db:          FloorReset,
    max_db:          16'sd0,
    attack_coeff:    16'd0,
    decay_coeff:     16'd60000,
    hold_ticks:      16'd90,
    peak_decay_step: 15'd85
  };

  // 20*log10(2) in Q.16
  localparam int unsigned DbConstW = 19;
  localparam logic [DbConstW-1:0] DbPerOctaveQ16 = 19'd394566;

  // result word: displayed, held, block peak, clip flag, clip count, zero pad
  localparam int unsigned OutFieldsW = 16 + 16 + 16 + 1 + 32;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // log2(1 + idx / 2^tbits) in Q0.16, one result bit per squaring
  function automatic logic [15:0] log_entry(input int unsigned idx, input int unsigned tbits);
    logic [63:0] y;
    logic [15:0] r;
    y = (64'd1 << 30) + (64'(idx) << (30 - tbits));
    r = '0;
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      r = {r[14:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        y    = y >> 1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/dbm_cfg_regs.sv
// Configuration register file of the peak meter.
// Depends on dbm_pkg for the register indexes, the cfg_t struct and reset values.
module dbm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [dbm_pkg::CfgIdxW-1:0]    wr_index_i,
  input  logic [dbm_pkg::CfgDataW-1:0]   wr_data_i,
  output dbm_pkg::cfg_t                  cfg_o
);
  import dbm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_CLIP_THRESHOLD:  cfg_d.clip_threshold  = wr_data_i[22:0];
        CFG_CLIP_RUN_LENGTH: cfg_d.clip_run_length = wr_data_i[7:0];
        CFG_MIN_DB:          cfg_d.min_db          = wr_data_i[15:0];
        CFG_MAX_DB:          cfg_d.max_db          = wr_data_i[15:0];
        CFG_ATTACK_COEFF:    cfg_d.attack_coeff    = wr_data_i[15:0];
        CFG_DECAY_COEFF:     cfg_d.decay_coeff     = wr_data_i[15:0];
        CFG_HOLD_TICKS:      cfg_d.hold_ticks      = wr_data_i[15:0];
        CFG_PEAK_DECAY_STEP: cfg_d.peak_decay_step = wr_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/dbm_clip_det.sv
// Per-sample magnitude tracking: running block maximum and clip run detector.
// Depends on dbm_pkg for request kinds and the configuration struct.
module dbm_clip_det #(
  parameter int unsigned SampleBits = dbm_pkg::SampleBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  dbm_pkg::req_e           req_i,
  input  logic [SampleBits-1:0]   sample_i,
  input  dbm_pkg::cfg_t           cfg_i,
  output logic [SampleBits-1:0]   running_max_o,
  output logic                    clip_flag_o,
  output logic [31:0]             clip_total_o
);
  import dbm_pkg::*;

  localparam int unsigned CmpW = (SampleBits > 23) ? SampleBits : 23;

  logic [SampleBits-1:0] mag;
  logic [SampleBits-1:0] max_q, max_d;
  logic [7:0]            run_q, run_d, run_inc;
  logic                  flag_q, flag_d;
  logic [31:0]           total_q, total_d;
  logic                  is_clip;

  // most negative sample keeps its full magnitude in SampleBits bits
  assign mag     = sample_i[SampleBits-1] ? (~sample_i + 1'b1) : sample_i;
  assign is_clip = CmpW'(mag) >= CmpW'(cfg_i.clip_threshold);
  assign run_inc = (run_q != 8'hFF) ? run_q + 8'd1 : run_q;

  always_comb begin
    max_d   = max_q;
    run_d   = run_q;
    flag_d  = flag_q;
    total_d = total_q;
    if (en_i) begin
      case (req_i)
        REQ_SAMPLE: begin
          if (mag > max_q) max_d = mag;
          if (is_clip) begin
            if (run_inc >= cfg_i.clip_run_length) begin
              flag_d  = 1'b1;
              total_d = total_q + 32'd1;
              run_d   = '0;
            end else begin
              run_d = run_inc;
            end
          end else begin
            run_d = '0;
          end
        end
        REQ_EOB: max_d = '0;
        REQ_ACK: begin
          flag_d = 1'b0;
          run_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      run_q   <= '0;
      flag_q  <= 1'b0;
      total_q <= '0;
    end else begin
      max_q   <= max_d;
      run_q   <= run_d;
      flag_q  <= flag_d;
      total_q <= total_d;
    end
  end

  assign running_max_o = max_q;
  assign clip_flag_o   = flag_q;
  assign clip_total_o  = total_q;

endmodule

>>> rtl/dbm_log.sv
// Magnitude to Q8.8 dBFS converter: leading-one search, mantissa table, dB scaling.
// Depends on dbm_pkg for the table function and the dB-per-octave constant.
module dbm_log #(
  parameter int unsigned SampleBits   = dbm_pkg::SampleBitsDef,
  parameter int unsigned LogTableBits = dbm_pkg::LogTableBitsDef
) (
  input  logic [SampleBits-1:0] mag_i,
  input  logic signed [15:0]    min_db_i,
  output logic signed [15:0]    db_o
);
  import dbm_pkg::*;

  localparam int unsigned TblSize = 1 << LogTableBits;
  localparam int unsigned PosW    = $clog2(SampleBits);
  localparam int unsigned NeglW   = PosW + 16;
  localparam int unsigned ProdW   = NeglW + DbConstW;
  localparam int unsigned RndW    = ProdW - 23;
  localparam int unsigned CmpW    = (RndW + 2 > 17) ? RndW + 2 : 17;
  localparam int unsigned ExtW    = SampleBits + LogTableBits;

  logic [15:0]             tbl [TblSize];
  logic [PosW-1:0]         pos;
  logic [PosW-1:0]         shamt;
  logic [SampleBits-1:0]   norm;
  logic [ExtW-1:0]         ext;
  logic [LogTableBits-1:0] idx;
  logic [NeglW-1:0]        negl;
  logic [ProdW-1:0]        prod;
  logic [ProdW:0]          rnd_sum;
  logic [RndW-1:0]         rounded;
  logic signed [CmpW-1:0]  db_wide;
  logic signed [CmpW-1:0]  min_ext;

  for (genvar i = 0; i < TblSize; i++) begin : g_tbl
    localparam logic [15:0] Entry = log_entry(i, LogTableBits);
    assign tbl[i] = Entry;
  end

  always_comb begin
    pos = '0;
    for (int b = 0; b < SampleBits; b++) begin
      if (mag_i[b]) pos = PosW'(b);
    end
  end

  // bring the leading one to the top, take the mantissa bits below it
  assign shamt = PosW'(SampleBits - 1) - pos;
  assign norm  = mag_i << shamt;
  assign ext   = {norm, {LogTableBits{1'b0}}};
  assign idx   = ext[ExtW-2 -: LogTableBits];

  // negated log2 in Q.16; never negative since a full-scale input has index zero
  assign negl    = {shamt, 16'h0000} - NeglW'(tbl[idx]);
  assign prod    = ProdW'(negl) * ProdW'(DbPerOctaveQ16);
  assign rnd_sum = (ProdW + 1)'(prod) + ((ProdW + 1)'(1) << 23);
  assign rounded = rnd_sum[ProdW:24];

  assign db_wide = -$signed(CmpW'(rounded));
  assign min_ext = CmpW'(min_db_i);

  assign db_o = ((mag_i == '0) || (db_wide < min_ext)) ? min_db_i : db_wide[15:0];

endmodule

>>> rtl/dbm_ballistics.sv
// Display ballistics: block level, attack/decay envelope and peak hold with decay.
// Depends on dbm_pkg for request kinds, the configuration struct and the reset floor.
module dbm_ballistics (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  dbm_pkg::req_e       req_i,
  input  logic signed [15:0]  blk_db_i,
  input  dbm_pkg::cfg_t       cfg_i,
  output logic signed [15:0]  block_db_o,
  output logic signed [15:0]  env_db_o,
  output logic signed [15:0]  held_db_o
);
  import dbm_pkg::*;

  logic signed [15:0] block_q, block_d;
  logic signed [15:0] env_q, env_d;
  logic signed [15:0] held_q, held_d;
  logic [15:0]        elapsed_q, elapsed_d, elapsed_inc;

  logic [15:0]        coeff;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] prod_adj;
  logic signed [16:0] scaled;
  logic signed [17:0] env_new;
  logic signed [17:0] block_ext;
  logic signed [17:0] held_dec;
  logic signed [17:0] held_new;

  // the ceiling wins when floor and ceiling cross
  function automatic logic signed [15:0] clamp_db(input logic signed [17:0] v,
                                                  input logic signed [15:0] lo,
                                                  input logic signed [15:0] hi);
    logic signed [17:0] r;
    r = v;
    if (r < 18'(lo)) r = 18'(lo);
    if (r > 18'(hi)) r = 18'(hi);
    return r[15:0];
  endfunction

  assign block_ext = 18'(block_q);
  assign coeff     = (block_q > env_q) ? cfg_i.attack_coeff : cfg_i.decay_coeff;
  assign diff      = 17'(env_q) - 17'(block_q);
  assign prod      = 34'(diff) * $signed({18'd0, coeff});
  // round the scaled difference toward zero
  assign prod_adj  = prod + (prod[33] ? 34'sd65535 : 34'sd0);
  assign scaled    = prod_adj[32:16];
  assign env_new   = block_ext + 18'(scaled);

  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign held_dec    = 18'(held_q) - $signed({3'b000, cfg_i.peak_decay_step});
  assign held_new    = (held_dec < block_ext) ? block_ext : held_dec;

  always_comb begin
    block_d   = block_q;
    env_d     = env_q;
    held_d    = held_q;
    elapsed_d = elapsed_q;
    if (en_i) begin
      case (req_i)
        REQ_EOB: block_d = blk_db_i;
        REQ_TICK: begin
          env_d = clamp_db(env_new, cfg_i.min_db, cfg_i.max_db);
          if (block_q >= held_q) begin
            held_d    = block_q;
            elapsed_d = '0;
          end else begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc > cfg_i.hold_ticks) begin
              held_d = clamp_db(held_new, cfg_i.min_db, cfg_i.max_db);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q   <= FloorReset;
      env_q     <= FloorReset;
      held_q    <= FloorReset;
      elapsed_q <= '0;
    end else begin
      block_q   <= block_d;
      env_q     <= env_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign block_db_o = block_q;
  assign env_db_o   = env_q;
  assign held_db_o  = held_q;

endmodule

>>> rtl/audio_peak_meter_clip_detect_unit.sv
// Top level of the audio peak meter with clip detection and peak hold.
// Depends on dbm_pkg, dbm_cfg_regs, dbm_clip_det, dbm_log and dbm_ballistics.
//
// Usage:
//  Requests enter on the s_axis channel: tuser holds the request kind (sample,
//  end of block, display tick, clip acknowledge), tdata the signed sample.
//  Every request gives one result on m_axis: displayed level, held peak, last
//  block peak (all Q8.8 dB), the clip latch and the wrapping clip count, taken
//  after the request has been applied.
//  A request is held in an input register, applied to the meter state once the
//  result slot is free or being emptied, and its result is valid from the next
//  edge on. One request is taken every cycle while m_axis does not stall; the
//  rate is set by the state update, whose longest path is the end-of-block
//  conversion (leading-one search, mantissa table, constant multiply, floor). When
//  m_axis stalls, the result is held, one more request is taken into the input
//  register and s_axis_tready then drops until the result is taken. Configuration
//  writes on the cfg channel are always ready; the user is to apply them only while
//  the meter is idle, which the block does not enforce. Reset clears the pipeline, sets
//  registers to their defaults, all levels to the default floor; requests in flight are lost.
module audio_peak_meter_clip_detect_unit #(
  parameter int unsigned SampleBits   = dbm_pkg::SampleBitsDef,
  parameter int unsigned LogTableBits = dbm_pkg::LogTableBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: sample, zero pad
  input  logic [((SampleBits + 7) / 8) * 8-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic [dbm_pkg::ReqW-1:0]              s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: displayed_db, peak_hold_db, block_peak_db, clip_latched, clip_count, zero pad
  output logic [dbm_pkg::OutDataW-1:0]          m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dbm_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [dbm_pkg::CfgDataW-1:0]          cfg_data_i
);
  import dbm_pkg::*;

  localparam int unsigned OutPadW = OutDataW - OutFieldsW;

  cfg_t                  cfg;
  logic                  in_valid_q, in_valid_d;
  req_e                  in_req_q;
  logic [SampleBits-1:0] in_sample_q;
  logic                  out_valid_q, out_valid_d;
  logic                  s_fire;
  logic                  advance;

  logic [SampleBits-1:0] running_max;
  logic                  clip_flag;
  logic [31:0]           clip_total;
  logic signed [15:0]    blk_db;
  logic signed [15:0]    block_db;
  logic signed [15:0]    env_db;
  logic signed [15:0]    held_db;

  assign cfg_ready_o = 1'b1;

  dbm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // apply the held request once the result slot is free or being emptied
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = s_fire | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_req_q    <= req_e'(s_axis_tuser);
      in_sample_q <= s_axis_tdata[SampleBits-1:0];
    end
  end

  dbm_clip_det #(
    .SampleBits (SampleBits)
  ) u_clip (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .req_i         (in_req_q),
    .sample_i      (in_sample_q),
    .cfg_i         (cfg),
    .running_max_o (running_max),
    .clip_flag_o   (clip_flag),
    .clip_total_o  (clip_total)
  );

  dbm_log #(
    .SampleBits   (SampleBits),
    .LogTableBits (LogTableBits)
  ) u_log (
    .mag_i    (running_max),
    .min_db_i (cfg.min_db),
    .db_o     (blk_db)
  );

  dbm_ballistics u_ballistics (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .req_i      (in_req_q),
    .blk_db_i   (blk_db),
    .cfg_i      (cfg),
    .block_db_o (block_db),
    .env_db_o   (env_db),
    .held_db_o  (held_db)
  );

  // state only moves on advance, so the state registers double as the result register
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, clip_total, clip_flag, block_db, held_db, env_db};

  // the clip count moves only when a sample is applied
  a_total_on_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_req_q == REQ_SAMPLE) |=> clip_total == $past(clip_total))
    else $error("clip count changed without a sample");

  // acknowledge drops the clip latch
  a_ack_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_req_q == REQ_ACK |=> !clip_flag)
    else $error("clip latch survived an acknowledge");

  // meter levels hold while no request is applied
  a_levels_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(env_db) && $stable(held_db) && $stable(block_db))
    else $error("levels moved without a request");

  // the input side backs up only when both stages are full and the output stalls
  a_ready_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

endmodule
